### rtl/wrsv_pkg.sv
// Shared types, constants and the CRC32C byte step for the log stream verifier.
`default_nettype none
package wrsv_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  localparam logic [6:0]  HdrLastIdx  = 7'd63;
  localparam logic [6:0]  RecLastIdx  = 7'd71;
  localparam logic [63:0] HdrBytes    = 64'd64;
  localparam logic [63:0] RecBytes    = 64'd72;
  localparam logic [63:0] WordBytes   = 64'd4;
  localparam logic [63:0] MagicWord   = 64'h0032_4C41_5750_4159;
  localparam logic [63:0] VersionWord = 64'h0000_0040_0000_0001;
  localparam logic [31:0] CrcPoly     = 32'h82F6_3B78;
  localparam logic [31:0] CrcPreset   = 32'hFFFF_FFFF;
  localparam logic [31:0] UpsertReset = 32'd0;
  localparam logic [31:0] DeleteReset = 32'd1;
  localparam logic [15:0] MaxOpsReset = 16'd10000;
  localparam logic [2:0]  TextCount   = 3'd5;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusFormat = 2'd1;
  localparam logic [1:0] StatusRange  = 2'd2;

  typedef enum logic [1:0] {
    CFG_UPSERT = 2'd0,
    CFG_DELETE = 2'd1,
    CFG_MAX_OPS = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_RECHDR,
    PH_TSEL,
    PH_TEXT,
    PH_VSTART,
    PH_VECTOR,
    PH_DONE,
    PH_STOP
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] operation_total;
    logic [63:0] base_gen;
    logic [63:0] target_gen;
  } out_item_t;

  // Reflected CRC32C update over one byte.
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/wrsv_in_queue.sv
// Front input queue: accepts byte transfers and hands them to the parser.
`default_nettype none
module wrsv_in_queue
  import wrsv_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_data_i,
  output logic          q_valid_o,
  input  wire logic     q_pop_i,
  output in_item_t      q_data_o
);

  in_item_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]       count_q;
  logic                     push, pop;

  assign in_ready_o = (count_q != QueuePtrW'(0) + (QueuePtrW+1)'(QueueDepth));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;
  assign q_valid_o  = (count_q != '0);
  assign q_data_o   = mem_q[rd_ptr_q];

  // Store incoming transfers.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

  // Advance pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

endmodule
`default_nettype wire

### rtl/wrsv_mul.sv
// Multi-cycle 64x64 multiplier built from four 32x32 partial products.
`default_nettype none
module wrsv_mul
  import wrsv_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic [63:0]      prod_lo_o,
  output logic             prod_hi_nz_o
);

  logic [2:0]   step_q;
  logic         run_q, pv_q;
  logic [63:0]  p_q;
  logic [1:0]   psh_q;
  logic [127:0] acc_q;
  logic [127:0] addend;
  logic [31:0]  a_part, b_part;

  assign a_part = step_q[0] ? a_i[63:32] : a_i[31:0];
  assign b_part = step_q[1] ? b_i[63:32] : b_i[31:0];

  // Align the registered partial product.
  always_comb begin
    case (psh_q)
      2'd0:    addend = {64'd0, p_q};
      2'd1:    addend = {32'd0, p_q, 32'd0};
      default: addend = {p_q, 64'd0};
    endcase
  end

  // Form one partial product per cycle.
  always_ff @(posedge clk_i) begin
    if (run_q && !step_q[2]) begin
      p_q   <= a_part * b_part;
      psh_q <= 2'(step_q[0]) + 2'(step_q[1]);
    end
    if (start_i)   acc_q <= '0;
    else if (pv_q) acc_q <= acc_q + addend;
  end

  // Sequence the four steps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      run_q  <= 1'b0;
      pv_q   <= 1'b0;
    end else if (start_i) begin
      step_q <= '0;
      run_q  <= 1'b1;
      pv_q   <= 1'b0;
    end else if (run_q) begin
      if (!step_q[2]) begin
        step_q <= step_q + 1'b1;
        pv_q   <= 1'b1;
      end else begin
        pv_q  <= 1'b0;
        run_q <= pv_q;
      end
    end
  end

  assign prod_lo_o    = acc_q[63:0];
  assign prod_hi_nz_o = (acc_q[127:64] != '0);

endmodule
`default_nettype wire

### rtl/wrsv_parser.sv
// Back end: walks header and records, keeps the CRC, latches errors, emits status.
`default_nettype none
module wrsv_parser
  import wrsv_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  output logic             q_pop_o,
  input  wire in_item_t    q_data_i,
  input  wire logic        cfg_valid_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_data_o
);

  phase_e      phase_q, phase_d;
  logic [63:0] pos_q, pos_d;
  logic [6:0]  fidx_q, fidx_d;
  logic [63:0] sh_q, sh_d;
  logic [31:0] crc_q, crc_d;
  logic [63:0] rem_q, rem_d;
  logic [15:0] recs_q, recs_d;
  logic [63:0] tl_q [5];
  logic [63:0] tl_d [5];
  logic [63:0] seg_q, seg_d;
  logic [63:0] vl_q, vl_d;
  logic [63:0] cnt0_q, cnt0_d, cnt1_q, cnt1_d;
  logic [63:0] hf_q [4];
  logic [63:0] hf_d [4];
  logic [1:0]  err_q, err_d;
  logic        hdr_ok_q, hdr_ok_d;
  logic [31:0] exp_crc_q, exp_crc_d;
  logic [31:0] kind_q, kind_d;
  logic [2:0]  ti_q, ti_d;
  logic        pend_q, pend_d;
  logic [31:0] upsert_q, delete_q;
  logic [15:0] maxop_q;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic        transient, consume, emit, mul_start;
  logic [63:0] word, len, rem_dec, mul_lo;
  logic        mul_hi_nz;
  logic [1:0]  fail_code, status;
  logic [15:0] recs_dec;

  wrsv_mul u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (mul_start),
    .a_i         (cnt0_q),
    .b_i         (cnt1_q),
    .prod_lo_o   (mul_lo),
    .prod_hi_nz_o(mul_hi_nz)
  );

  // Handshake and emit control.
  always_comb begin
    transient = (phase_q == PH_TSEL) || (phase_q == PH_VSTART);
    consume   = q_valid_i && !pend_q && !transient;
    emit      = pend_q && !transient && (!out_valid_q || out_ready_i);
    q_pop_o   = consume;
  end

  // Final status from the stream state.
  always_comb begin
    if (pos_q < HdrBytes || !hdr_ok_q)           status = StatusFormat;
    else if (hf_q[3] != pos_q - HdrBytes)         status = StatusFormat;
    else if (err_q != StatusOk)                   status = err_q;
    else if (phase_q != PH_DONE || rem_q != '0 || ~crc_q != exp_crc_q)
                                                  status = StatusFormat;
    else                                          status = StatusOk;
  end

  // Next-state and datapath.
  always_comb begin
    phase_d = phase_q;  pos_d = pos_q;  fidx_d = fidx_q;  sh_d = sh_q;
    crc_d = crc_q;  rem_d = rem_q;  recs_d = recs_q;  seg_d = seg_q;  vl_d = vl_q;
    cnt0_d = cnt0_q;  cnt1_d = cnt1_q;  err_d = err_q;  hdr_ok_d = hdr_ok_q;
    exp_crc_d = exp_crc_q;  kind_d = kind_q;  ti_d = ti_q;  pend_d = pend_q;
    tl_d = tl_q;  hf_d = hf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d = out_q;
    mul_start = 1'b0;
    fail_code = StatusOk;
    word = {q_data_i.data_byte, sh_q[63:8]};
    rem_dec = rem_q - 64'd1;
    recs_dec = recs_q - 16'd1;
    len = tl_q[ti_q];

    if (emit) begin
      out_valid_d = 1'b1;
      out_d.status          = status;
      out_d.operation_total = hf_q[2][15:0];
      out_d.base_gen        = hf_q[0];
      out_d.target_gen      = hf_q[1];
      // Clear the stream for the next file.
      phase_d = PH_HEADER;  pos_d = '0;  fidx_d = '0;  crc_d = CrcPreset;
      rem_d = '0;  recs_d = '0;  seg_d = '0;  vl_d = '0;  cnt0_d = '0;  cnt1_d = '0;
      err_d = StatusOk;  hdr_ok_d = 1'b0;  exp_crc_d = '0;  kind_d = '0;  ti_d = '0;
      pend_d = 1'b0;
      for (int i = 0; i < 5; i++) tl_d[i] = '0;
      for (int i = 0; i < 4; i++) hf_d[i] = '0;
    end else if (consume) begin
      pos_d  = pos_q + 64'd1;
      sh_d   = word;
      pend_d = q_data_i.last_byte;
      unique case (phase_q)
        PH_HEADER: begin
          if (fidx_q[2:0] == 3'd7) begin
            case (fidx_q[5:3])
              3'd0: hdr_ok_d = (word == MagicWord);
              3'd1: if (word != VersionWord) hdr_ok_d = 1'b0;
              3'd2: hf_d[0] = word;
              3'd3: hf_d[1] = word;
              3'd4: hf_d[2] = word;
              3'd5: hf_d[3] = word;
              3'd6: exp_crc_d = word[31:0];
              default: ;
            endcase
          end
          fidx_d = fidx_q + 7'd1;
          if (fidx_q == HdrLastIdx) begin
            if (!hdr_ok_q || hf_q[2] == '0 || hf_q[2][63:16] != '0 ||
                hf_q[2][15:0] > maxop_q || hf_q[0] == '1 ||
                hf_q[1] != hf_q[0] + 64'd1) begin
              hdr_ok_d  = 1'b0;
              fail_code = StatusFormat;
            end else begin
              rem_d  = hf_q[3];
              recs_d = hf_q[2][15:0];
              if (hf_q[3] < RecBytes) fail_code = StatusFormat;
              else begin
                phase_d = PH_RECHDR;
                fidx_d  = '0;
              end
            end
          end
        end
        PH_RECHDR: begin
          crc_d = crc_byte(crc_q, q_data_i.data_byte);
          rem_d = rem_dec;
          if (fidx_q[2:0] == 3'd7) begin
            case (fidx_q[6:3])
              4'd0: kind_d = word[31:0];
              4'd2: cnt0_d = word;
              4'd3: begin
                cnt1_d    = word;
                mul_start = 1'b1;
              end
              4'd4: tl_d[0] = word;
              4'd5: tl_d[1] = word;
              4'd6: tl_d[2] = word;
              4'd7: tl_d[3] = word;
              4'd8: tl_d[4] = word;
              default: ;
            endcase
          end
          fidx_d = fidx_q + 7'd1;
          if (fidx_q == RecLastIdx) begin
            if ((kind_q != upsert_q && kind_q != delete_q) || mul_hi_nz) begin
              fail_code = StatusFormat;
            end else begin
              ti_d    = '0;
              phase_d = PH_TSEL;
            end
          end
        end
        PH_TEXT: begin
          crc_d = crc_byte(crc_q, q_data_i.data_byte);
          rem_d = rem_dec;
          seg_d = seg_q - 64'd1;
          if (seg_q == 64'd1) begin
            ti_d    = ti_q + 3'd1;
            phase_d = PH_TSEL;
          end
        end
        PH_VECTOR: begin
          crc_d = crc_byte(crc_q, q_data_i.data_byte);
          rem_d = rem_dec;
          seg_d = seg_q - 64'd1;
          if (seg_q == 64'd1) begin
            vl_d = vl_q - 64'd1;
            if (vl_q != 64'd1) begin
              if (rem_dec < WordBytes) fail_code = StatusFormat;
              else seg_d = WordBytes;
            end else if (tl_q[0] == '0) begin
              fail_code = StatusFormat;
            end else begin
              recs_d = recs_dec;
              if (recs_dec == '0)           phase_d = PH_DONE;
              else if (rem_dec < RecBytes)  fail_code = StatusFormat;
              else begin
                phase_d = PH_RECHDR;
                fidx_d  = '0;
              end
            end
          end
        end
        PH_DONE: fail_code = StatusFormat;
        default: ;
      endcase
    end else if (phase_q == PH_TSEL) begin
      // Pick the next non-empty text, one length per cycle.
      if (ti_q == TextCount)      phase_d = PH_VSTART;
      else if (len == '1)         fail_code = StatusRange;
      else if (len > rem_q)       fail_code = StatusFormat;
      else if (len != '0) begin
        seg_d   = len;
        phase_d = PH_TEXT;
      end else ti_d = ti_q + 3'd1;
    end else if (phase_q == PH_VSTART) begin
      if (mul_lo == '0) begin
        if (tl_q[0] == '0) fail_code = StatusFormat;
        else begin
          recs_d = recs_dec;
          if (recs_dec == '0)        phase_d = PH_DONE;
          else if (rem_q < RecBytes) fail_code = StatusFormat;
          else begin
            phase_d = PH_RECHDR;
            fidx_d  = '0;
          end
        end
      end else if (mul_lo[63:62] != 2'b00) begin
        fail_code = StatusRange;
      end else begin
        vl_d = mul_lo;
        if (rem_q < WordBytes) fail_code = StatusFormat;
        else begin
          seg_d   = WordBytes;
          phase_d = PH_VECTOR;
        end
      end
    end

    // Latch the first error and stop parsing.
    if (fail_code != StatusOk) begin
      if (err_q == StatusOk) err_d = fail_code;
      phase_d = PH_STOP;
    end
  end

  // Stream payload registers.
  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;  rem_q <= rem_d;  recs_q <= recs_d;  seg_q <= seg_d;  vl_q <= vl_d;
    cnt0_q <= cnt0_d;  cnt1_q <= cnt1_d;  exp_crc_q <= exp_crc_d;  kind_q <= kind_d;
    tl_q <= tl_d;  out_q <= out_d;
  end

  // Control state, header fields and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;  pos_q <= '0;  fidx_q <= '0;  crc_q <= CrcPreset;
      err_q <= StatusOk;  hdr_ok_q <= 1'b0;  ti_q <= '0;  pend_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) hf_q[i] <= '0;
      upsert_q <= UpsertReset;  delete_q <= DeleteReset;  maxop_q <= MaxOpsReset;
    end else begin
      phase_q <= phase_d;  pos_q <= pos_d;  fidx_q <= fidx_d;  crc_q <= crc_d;
      err_q <= err_d;  hdr_ok_q <= hdr_ok_d;  ti_q <= ti_d;  pend_q <= pend_d;
      out_valid_q <= out_valid_d;
      hf_q <= hf_d;
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_UPSERT:  upsert_q <= cfg_data_i;
          CFG_DELETE:  delete_q <= cfg_data_i;
          CFG_MAX_OPS: maxop_q  <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

### rtl/wal_record_stream_verifier.sv
// Top level of the write-ahead-log stream verifier.
//
// Input channel: one log byte per transfer, last_byte marks the file's end.
// Output channel: one status transfer per file (ok, invalid format, out of
// range) with the declared operation count and both generations.
// Config channel: index 0 upsert kind, 1 delete kind, 2 max operations; always
// ready. The user must see that it is written only while no file is in flight;
// the block does not enforce this. Bytes pass a 4-entry input queue into the
// parser, which takes one byte per cycle while it is not waiting to emit a
// file's status or stepping between states. After each record header the parser
// steps through the five text slots, then closes the text walk and starts the
// vector words, taking no bytes in those steps. The count*dimensions product
// runs on a 4-step 32x32 multiplier hidden inside the record header.
// Reset empties the queue, returns the parser to its header phase, drops the
// output valid and restores the configuration defaults. A stalled receiver
// holds the status; the parser then stops at the next file's last byte and the
// queue fills, dropping in_ready_o.
`default_nettype none
module wal_record_stream_verifier
  import wrsv_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  logic     q_valid, q_pop;
  in_item_t q_data;

  assign cfg_ready_o = 1'b1;

  wrsv_in_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop),
    .q_data_o  (q_data)
  );

  wrsv_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .q_data_i   (q_data),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

### rtl/wrsv_checker.sv
// Port-level checks for the log stream verifier, bound to the top level.
`default_nettype none
module wrsv_checker
  import wrsv_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_data_o
);

  // Hold a stalled status transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled status transfer changed");

  // Status code stays within its defined set.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == StatusOk ||
                     out_data_o.status == StatusFormat ||
                     out_data_o.status == StatusRange))
    else $error("undefined status code");

  // A passing file declared at least one operation.
  a_ok_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StatusOk |-> out_data_o.operation_total != '0)
    else $error("ok status with zero operations");

  // Come out of reset empty and ready.
  a_reset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_ready_o && !out_valid_o)
    else $error("not idle after reset");

endmodule

bind wal_record_stream_verifier wrsv_checker u_wrsv_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
`default_nettype wire
